@@ hdl/ttq_pkg.sv @@
// Shared types, codes and helpers for the tag tap qualifier.
package ttq_pkg;

  // Widths fixed by the item and result fields.
  localparam int unsigned UidLowW  = 64;
  localparam int unsigned UidHighW = 16;
  localparam int unsigned UidLenW  = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 2;

  // Longest UID in bytes; longer lengths saturate to this.
  localparam logic [UidLenW-1:0] MaxUidBytes = 4'd10;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDupWindow   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBusyCool    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRetryIntvl  = 2'd2;

  // Configuration reset values.
  localparam logic [CfgW-1:0] DupWindowReset  = 32'd2000;
  localparam logic [CfgW-1:0] BusyCoolReset   = 32'd1500;
  localparam logic [CfgW-1:0] RetryIntvlReset = 32'd3000;

  // Item kinds.
  localparam logic FuncStart = 1'b0;
  localparam logic FuncPoll  = 1'b1;

  // Operating mode, one-hot.
  typedef enum logic [3:0] {
    ModeIdle  = 4'b0001,
    ModeReady = 4'b0010,
    ModeBusy  = 4'b0100,
    ModeError = 4'b1000
  } mode_e;

  // Mode codes as seen on the result port.
  localparam logic [1:0] ModeCodeIdle  = 2'd0;
  localparam logic [1:0] ModeCodeReady = 2'd1;
  localparam logic [1:0] ModeCodeBusy  = 2'd2;
  localparam logic [1:0] ModeCodeError = 2'd3;

  typedef enum logic [3:0] {
    OutNone       = 4'd0,
    OutDuplicate  = 4'd1,
    OutBusyReject = 4'd2,
    OutTap        = 4'd3,
    OutErrorWait  = 4'd4,
    OutRetryFail  = 4'd5,
    OutRecovered  = 4'd6,
    OutStartFail  = 4'd7,
    OutStartOk    = 4'd8
  } outcome_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic                func;
    logic                reader_ok;
    logic                tag_present;
    logic [UidLowW-1:0]  uid_low;
    logic [UidHighW-1:0] uid_high;
    logic [UidLenW-1:0]  uid_len;
    logic [TimeW-1:0]    now_ms;
  } item_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] code;
    case (m)
      ModeIdle:  code = ModeCodeIdle;
      ModeReady: code = ModeCodeReady;
      ModeBusy:  code = ModeCodeBusy;
      ModeError: code = ModeCodeError;
      default:   code = ModeCodeIdle;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/ttq_front.sv @@
// Front stage: takes items, saturates the UID length and clears unused UID bytes.
module ttq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          func_i,
  input  logic                          reader_ok_i,
  input  logic                          tag_present_i,
  input  logic [ttq_pkg::UidLowW-1:0]   uid_low_i,
  input  logic [ttq_pkg::UidHighW-1:0]  uid_high_i,
  input  logic [ttq_pkg::UidLenW-1:0]   uid_len_i,
  input  logic [ttq_pkg::TimeW-1:0]     now_ms_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ttq_pkg::item_t                item_o
);

  logic           valid_d, valid_q;
  ttq_pkg::item_t item_d, item_q;
  logic           accept;
  logic [ttq_pkg::UidLenW-1:0] len_sat;

  assign full_o = valid_q && !ready_i;
  assign accept = push_i && !full_o;

  always_comb begin
    len_sat = (uid_len_i > ttq_pkg::MaxUidBytes) ? ttq_pkg::MaxUidBytes : uid_len_i;
    item_d.func        = func_i;
    item_d.reader_ok   = reader_ok_i;
    item_d.tag_present = tag_present_i;
    item_d.uid_len     = len_sat;
    item_d.now_ms      = now_ms_i;
    // Bytes at or beyond the length are forced to zero.
    for (int i = 0; i < 8; i++) begin
      item_d.uid_low[8*i +: 8] = (len_sat > 4'(i)) ? uid_low_i[8*i +: 8] : 8'd0;
    end
    for (int j = 0; j < 2; j++) begin
      item_d.uid_high[8*j +: 8] = (len_sat > 4'(8 + j)) ? uid_high_i[8*j +: 8] : 8'd0;
    end
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hdl/ttq_fifo.sv @@
// Short queue of classified items between the front and the back.
module ttq_fifo #(
  parameter int unsigned Depth = ttq_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  ttq_pkg::item_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output ttq_pkg::item_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  ttq_pkg::item_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != Full);
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hdl/ttq_core.sv @@
// Back part: configuration registers, mode and tag history, and the result register.
module ttq_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ttq_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ttq_pkg::item_t                item_i,
  output logic                          res_valid_o,
  input  logic                          res_pop_i,
  output logic [3:0]                    outcome_o,
  output logic                          became_ready_o,
  output logic [1:0]                    mode_out_o,
  output logic [ttq_pkg::UidLowW-1:0]   event_uid_low_o,
  output logic [ttq_pkg::UidHighW-1:0]  event_uid_high_o,
  output logic [ttq_pkg::UidLenW-1:0]   event_uid_len_o,
  output logic [ttq_pkg::TimeW-1:0]     event_time_ms_o,
  output logic [ttq_pkg::TimeW-1:0]     event_seq_o
);

  logic [ttq_pkg::CfgW-1:0] dup_win_q, busy_cool_q, retry_iv_q;

  ttq_pkg::mode_e                mode_d, mode_q;
  logic [ttq_pkg::UidLowW-1:0]   last_low_d, last_low_q;
  logic [ttq_pkg::UidHighW-1:0]  last_high_d, last_high_q;
  logic [ttq_pkg::UidLenW-1:0]   last_len_d, last_len_q;
  logic [ttq_pkg::TimeW-1:0]     last_seen_d, last_seen_q;
  logic [ttq_pkg::TimeW-1:0]     busy_until_d, busy_until_q;
  logic [ttq_pkg::TimeW-1:0]     last_retry_d, last_retry_q;
  logic [ttq_pkg::TimeW-1:0]     tap_cnt_d, tap_cnt_q;

  logic                          out_valid_d, out_valid_q;
  ttq_pkg::outcome_e             res_outcome;
  logic                          res_ready_flag;
  logic                          res_tap;
  logic [3:0]                    outcome_q;
  logic                          ready_flag_q;
  logic [1:0]                    mode_out_q;
  logic [ttq_pkg::UidLowW-1:0]   ev_low_q;
  logic [ttq_pkg::UidHighW-1:0]  ev_high_q;
  logic [ttq_pkg::UidLenW-1:0]   ev_len_q;
  logic [ttq_pkg::TimeW-1:0]     ev_time_q, ev_seq_q;

  logic                          fire;
  logic [ttq_pkg::TimeW-1:0]     since_retry, since_seen;
  logic                          retry_due, expired, dup;
  ttq_pkg::mode_e                eff_mode;

  assign ready_o = !out_valid_q || res_pop_i;
  assign fire    = valid_i && ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_win_q   <= ttq_pkg::DupWindowReset;
      busy_cool_q <= ttq_pkg::BusyCoolReset;
      retry_iv_q  <= ttq_pkg::RetryIntvlReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttq_pkg::CfgDupWindow:  dup_win_q   <= cfg_data_i;
        ttq_pkg::CfgBusyCool:   busy_cool_q <= cfg_data_i;
        ttq_pkg::CfgRetryIntvl: retry_iv_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    since_retry = item_i.now_ms - last_retry_q;
    since_seen  = item_i.now_ms - last_seen_q;
    retry_due   = since_retry > retry_iv_q;
    expired     = (mode_q == ttq_pkg::ModeBusy) && (item_i.now_ms >= busy_until_q);
    eff_mode    = expired ? ttq_pkg::ModeReady : mode_q;
    dup         = (item_i.uid_len == last_len_q) && (item_i.uid_low == last_low_q) &&
                  (item_i.uid_high == last_high_q) && (since_seen < dup_win_q);
  end

  always_comb begin
    mode_d         = mode_q;
    last_low_d     = last_low_q;
    last_high_d    = last_high_q;
    last_len_d     = last_len_q;
    last_seen_d    = last_seen_q;
    busy_until_d   = busy_until_q;
    last_retry_d   = last_retry_q;
    tap_cnt_d      = tap_cnt_q;
    res_outcome    = ttq_pkg::OutNone;
    res_ready_flag = 1'b0;
    res_tap        = 1'b0;
    if (item_i.func == ttq_pkg::FuncStart) begin
      mode_d      = item_i.reader_ok ? ttq_pkg::ModeReady : ttq_pkg::ModeError;
      res_outcome = item_i.reader_ok ? ttq_pkg::OutStartOk : ttq_pkg::OutStartFail;
    end else begin
      case (mode_q)
        ttq_pkg::ModeIdle: begin
          res_outcome = ttq_pkg::OutNone;
        end
        ttq_pkg::ModeError: begin
          if (retry_due) begin
            last_retry_d = item_i.now_ms;
            if (item_i.reader_ok) begin
              mode_d      = ttq_pkg::ModeReady;
              res_outcome = ttq_pkg::OutRecovered;
            end else begin
              res_outcome = ttq_pkg::OutRetryFail;
            end
          end else begin
            res_outcome = ttq_pkg::OutErrorWait;
          end
        end
        default: begin
          mode_d         = eff_mode;
          res_ready_flag = expired;
          if (!item_i.tag_present) begin
            res_outcome = ttq_pkg::OutNone;
          end else if (dup) begin
            last_seen_d = item_i.now_ms;
            res_outcome = ttq_pkg::OutDuplicate;
          end else if (eff_mode == ttq_pkg::ModeBusy) begin
            res_outcome = ttq_pkg::OutBusyReject;
          end else begin
            res_outcome  = ttq_pkg::OutTap;
            res_tap      = 1'b1;
            tap_cnt_d    = tap_cnt_q + 1'b1;
            last_low_d   = item_i.uid_low;
            last_high_d  = item_i.uid_high;
            last_len_d   = item_i.uid_len;
            last_seen_d  = item_i.now_ms;
            mode_d       = ttq_pkg::ModeBusy;
            busy_until_d = item_i.now_ms + busy_cool_q;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ttq_pkg::ModeIdle;
      last_low_q   <= '0;
      last_high_q  <= '0;
      last_len_q   <= '0;
      last_seen_q  <= '0;
      busy_until_q <= '0;
      last_retry_q <= '0;
      tap_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        mode_q       <= mode_d;
        last_low_q   <= last_low_d;
        last_high_q  <= last_high_d;
        last_len_q   <= last_len_d;
        last_seen_q  <= last_seen_d;
        busy_until_q <= busy_until_d;
        last_retry_q <= last_retry_d;
        tap_cnt_q    <= tap_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      outcome_q    <= res_outcome;
      ready_flag_q <= res_ready_flag;
      mode_out_q   <= ttq_pkg::mode_code(mode_d);
      ev_low_q     <= res_tap ? item_i.uid_low  : '0;
      ev_high_q    <= res_tap ? item_i.uid_high : '0;
      ev_len_q     <= res_tap ? item_i.uid_len  : '0;
      ev_time_q    <= res_tap ? item_i.now_ms   : '0;
      ev_seq_q     <= res_tap ? tap_cnt_q       : '0;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign became_ready_o   = ready_flag_q;
  assign mode_out_o       = mode_out_q;
  assign event_uid_low_o  = ev_low_q;
  assign event_uid_high_o = ev_high_q;
  assign event_uid_len_o  = ev_len_q;
  assign event_time_ms_o  = ev_time_q;
  assign event_seq_o      = ev_seq_q;

endmodule

@@ hdl/tag_tap_qualifier.sv @@
// Top level of the tag tap qualifier: front stage, item queue and back part.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  -----------------------------------------------
//   items     push / full            func, reader_ok, tag_present, uid_*, now_ms
//   results   empty / pop            outcome, became_ready, mode_out, event_*
//   config    cfg_we_i               cfg_idx_i selects the register, cfg_data_i
//
// The block sustains one item per clock cycle while results are popped. An item is
// registered in the front stage, which saturates the UID length and clears unused UID
// bytes, then waits in a short queue until the back part decides on it and loads the
// result register. The decision in the back part, with its 32-bit subtractions and
// compares, sets that rate. Reset puts the block in the not-started mode with the
// default windows and a cleared tag history. When results are not popped, the result
// register holds, the queue fills behind it and full rises only once the front stage
// is also occupied.
module tag_tap_qualifier #(
  parameter int unsigned QueueDepth = ttq_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic                          reader_ok_i,
  input  logic                          tag_present_i,
  input  logic [ttq_pkg::UidLowW-1:0]   uid_low_i,
  input  logic [ttq_pkg::UidHighW-1:0]  uid_high_i,
  input  logic [ttq_pkg::UidLenW-1:0]   uid_len_i,
  input  logic [ttq_pkg::TimeW-1:0]     now_ms_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [3:0]                    outcome_o,
  output logic                          became_ready_o,
  output logic [1:0]                    mode_out_o,
  output logic [ttq_pkg::UidLowW-1:0]   event_uid_low_o,
  output logic [ttq_pkg::UidHighW-1:0]  event_uid_high_o,
  output logic [ttq_pkg::UidLenW-1:0]   event_uid_len_o,
  output logic [ttq_pkg::TimeW-1:0]     event_time_ms_o,
  output logic [ttq_pkg::TimeW-1:0]     event_seq_o,
  input  logic                          cfg_we_i,
  input  logic [ttq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ttq_pkg::CfgW-1:0]      cfg_data_i
);

  // Front stage to queue.
  logic           front_valid, front_ready;
  ttq_pkg::item_t front_item;

  // Queue to back part.
  logic           q_valid, q_ready;
  ttq_pkg::item_t q_item;

  logic           res_valid;

  ttq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .func_i        (func_i),
    .reader_ok_i   (reader_ok_i),
    .tag_present_i (tag_present_i),
    .uid_low_i     (uid_low_i),
    .uid_high_i    (uid_high_i),
    .uid_len_i     (uid_len_i),
    .now_ms_i      (now_ms_i),
    .valid_o       (front_valid),
    .ready_i       (front_ready),
    .item_o        (front_item)
  );

  ttq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_item)
  );

  ttq_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .valid_i          (q_valid),
    .ready_o          (q_ready),
    .item_i           (q_item),
    .res_valid_o      (res_valid),
    .res_pop_i        (pop),
    .outcome_o        (outcome_o),
    .became_ready_o   (became_ready_o),
    .mode_out_o       (mode_out_o),
    .event_uid_low_o  (event_uid_low_o),
    .event_uid_high_o (event_uid_high_o),
    .event_uid_len_o  (event_uid_len_o),
    .event_time_ms_o  (event_time_ms_o),
    .event_seq_o      (event_seq_o)
  );

  // A result waits in the back part's register until it is popped.
  assign empty = !res_valid;

endmodule

@@ bench/tb_tag_tap_qualifier.sv @@
// Self-checking testbench for the tag tap qualifier: directed table, random reads, predictor.
`timescale 1ns / 100ps

module tb_tag_tap_qualifier;
  import ttq_pkg::*;

  // Idle slack after the last result, the length of the forced receiver stall, and the
  // number of transfer-free cycles after which the run is declared hung.
  localparam int DrainCycles   = 8;
  localparam int LongHold      = 48;
  localparam int WatchdogLimit = 1000;
  localparam int ReadsPerPhase = 220;
  localparam int PhaseCount    = 5;

  // Index 3 is outside the register list, so writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // One qualified result as the block should present it.
  typedef struct packed {
    outcome_e              outcome;
    logic                  became_ready;
    logic [1:0]            mode;
    logic [UidLowW-1:0]    ev_low;
    logic [UidHighW-1:0]   ev_high;
    logic [UidLenW-1:0]    ev_len;
    logic [TimeW-1:0]      ev_time;
    logic [TimeW-1:0]      ev_seq;
  } tap_result_t;

  // A row of the directed script. Where the outcome and mode follow at a glance they are
  // typed in and override the prediction; the event fields always come from the predictor.
  typedef struct packed {
    item_t      rd;
    logic       typed;
    outcome_e   outcome;
    logic [1:0] mode;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic                 func_i;
  logic                 reader_ok_i;
  logic                 tag_present_i;
  logic [UidLowW-1:0]   uid_low_i;
  logic [UidHighW-1:0]  uid_high_i;
  logic [UidLenW-1:0]   uid_len_i;
  logic [TimeW-1:0]     now_ms_i;
  logic                 empty;
  logic                 pop;
  logic [3:0]           outcome_o;
  logic                 became_ready_o;
  logic [1:0]           mode_out_o;
  logic [UidLowW-1:0]   event_uid_low_o;
  logic [UidHighW-1:0]  event_uid_high_o;
  logic [UidLenW-1:0]   event_uid_len_o;
  logic [TimeW-1:0]     event_time_ms_o;
  logic [TimeW-1:0]     event_seq_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_data_i;

  tag_tap_qualifier dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .func_i           (func_i),
    .reader_ok_i      (reader_ok_i),
    .tag_present_i    (tag_present_i),
    .uid_low_i        (uid_low_i),
    .uid_high_i       (uid_high_i),
    .uid_len_i        (uid_len_i),
    .now_ms_i         (now_ms_i),
    .empty            (empty),
    .pop              (pop),
    .outcome_o        (outcome_o),
    .became_ready_o   (became_ready_o),
    .mode_out_o       (mode_out_o),
    .event_uid_low_o  (event_uid_low_o),
    .event_uid_high_o (event_uid_high_o),
    .event_uid_len_o  (event_uid_len_o),
    .event_time_ms_o  (event_time_ms_o),
    .event_seq_o      (event_seq_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the qualifier: window settings and tag history, starting from reset.
  logic [CfgW-1:0]      win_dup     = DupWindowReset;
  logic [CfgW-1:0]      win_cool    = BusyCoolReset;
  logic [CfgW-1:0]      win_retry   = RetryIntvlReset;
  logic [1:0]           sh_mode     = ModeCodeIdle;
  logic [UidLowW-1:0]   sh_uid_low  = '0;
  logic [UidHighW-1:0]  sh_uid_high = '0;
  logic [UidLenW-1:0]   sh_uid_len  = '0;
  logic [TimeW-1:0]     sh_seen_ms  = '0;
  logic [TimeW-1:0]     sh_busy_end = '0;
  logic [TimeW-1:0]     sh_retry_ms = '0;
  logic [TimeW-1:0]     sh_taps     = '0;

  // Results predicted for reads already transferred in, oldest first.
  tap_result_t predicted_verdicts[$];

  // Random-read state: a running millisecond clock and a small pool of tags, so that
  // repeats and duplicates come up often.
  logic [TimeW-1:0]     ms_clock;
  logic [UidLowW-1:0]   pool_low [4];
  logic [UidHighW-1:0]  pool_high [4];
  logic [UidLenW-1:0]   pool_len [4];

  bit hold_request;
  bit calm;
  int unsigned mismatches;
  int unsigned reads_sent;
  int unsigned verdicts_seen;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  int unsigned outcome_tally [16];

  // Directed script, run from reset with the default windows (2000 / 1500 / 3000 ms).
  script_row_t read_script [23] = '{
    // A poll before any start is ignored, whatever the tag.
    '{'{FuncPoll, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd10, 32'd100},
      1'b1, OutNone, ModeCodeIdle},
    '{'{FuncStart, 1'b1, 1'b0, 64'h0, 16'h0, 4'd0, 32'd110},
      1'b1, OutStartOk, ModeCodeReady},
    // A zero-length tag matches the cleared history from reset; all its bytes are ignored.
    '{'{FuncPoll, 1'b0, 1'b1, 64'hA5A5_0000_1111_2222, 16'h5A5A, 4'd0, 32'd120},
      1'b1, OutDuplicate, ModeCodeReady},
    // Overlong length saturates to ten bytes.
    '{'{FuncPoll, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd15, 32'd130},
      1'b1, OutTap, ModeCodeBusy},
    '{'{FuncPoll, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd10, 32'd140},
      1'b1, OutDuplicate, ModeCodeBusy},
    '{'{FuncPoll, 1'b1, 1'b1, 64'h0123_4567_ABCD_1234, 16'hFFFF, 4'd4, 32'd150},
      1'b1, OutBusyReject, ModeCodeBusy},
    // One millisecond before and exactly at the end of the cooldown.
    '{'{FuncPoll, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd10, 32'd1629},
      1'b1, OutNone, ModeCodeBusy},
    '{'{FuncPoll, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd10, 32'd1630},
      1'b0, OutNone, ModeCodeIdle},
    // Bytes beyond the length are garbage and must not reach the event.
    '{'{FuncPoll, 1'b0, 1'b1, 64'hFFFF_FFFF_DEAD_BEEF, 16'hFFFF, 4'd4, 32'd1640},
      1'b0, OutNone, ModeCodeIdle},
    // Same tag one millisecond inside the window, then exactly at its end.
    '{'{FuncPoll, 1'b0, 1'b1, 64'h1234_5678_DEAD_BEEF, 16'h0000, 4'd4, 32'd3639},
      1'b0, OutNone, ModeCodeIdle},
    '{'{FuncPoll, 1'b0, 1'b1, 64'h0000_0000_DEAD_BEEF, 16'h0000, 4'd4, 32'd5639},
      1'b0, OutNone, ModeCodeIdle},
    // Same bytes but a different length is a different tag.
    '{'{FuncPoll, 1'b0, 1'b1, 64'h0000_0000_DEAD_BEEF, 16'h0000, 4'd5, 32'd5640},
      1'b1, OutBusyReject, ModeCodeBusy},
    '{'{FuncStart, 1'b0, 1'b1, 64'h0, 16'h0, 4'd3, 32'd5650},
      1'b1, OutStartFail, ModeCodeError},
    '{'{FuncPoll, 1'b0, 1'b1, 64'h0, 16'h0, 4'd3, 32'd5660},
      1'b1, OutRetryFail, ModeCodeError},
    // The retry gap must be strictly longer than the interval.
    '{'{FuncPoll, 1'b1, 1'b1, 64'h0, 16'h0, 4'd3, 32'd8660},
      1'b1, OutErrorWait, ModeCodeError},
    '{'{FuncPoll, 1'b1, 1'b0, 64'h0, 16'h0, 4'd3, 32'd8661},
      1'b1, OutRecovered, ModeCodeReady},
    '{'{FuncStart, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd15, 32'd8670},
      1'b1, OutStartOk, ModeCodeReady},
    // Tap just below the clock wrap; the cooldown end wraps to a small value.
    '{'{FuncPoll, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 16'hFFFF, 4'd8, 32'hFFFF_FF00},
      1'b0, OutNone, ModeCodeIdle},
    '{'{FuncPoll, 1'b1, 1'b0, 64'h0, 16'h0, 4'd0, 32'hFFFF_FFFF},
      1'b0, OutNone, ModeCodeIdle},
    // Duplicate window measured across the wrap.
    '{'{FuncPoll, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 16'h0000, 4'd8, 32'h0000_0100},
      1'b1, OutDuplicate, ModeCodeReady},
    '{'{FuncPoll, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hAB12, 4'd9, 32'h0000_0200},
      1'b0, OutNone, ModeCodeIdle},
    '{'{FuncPoll, 1'b0, 1'b1, 64'h0, 16'h0, 4'd10, 32'h0000_0300},
      1'b1, OutBusyReject, ModeCodeBusy},
    // A failed start drops a busy block straight into error, with the clock now below
    // the last retry time.
    '{'{FuncStart, 1'b0, 1'b0, 64'h0, 16'h0, 4'd0, 32'h0000_0310},
      1'b1, OutStartFail, ModeCodeError}
  };

  // Predicts the result of one read and advances the shadow state.
  function automatic tap_result_t qualify_read(input item_t rd);
    tap_result_t v;
    logic [UidLenW-1:0]  len;
    logic [UidLowW-1:0]  ulow;
    logic [UidHighW-1:0] uhigh;
    logic [TimeW-1:0]    since;
    int b;
    v = '0;
    v.outcome = OutNone;
    len = (rd.uid_len > MaxUidBytes) ? MaxUidBytes : rd.uid_len;
    ulow = rd.uid_low;
    uhigh = rd.uid_high;
    for (b = 0; b < int'(MaxUidBytes); b++) begin
      if (b >= int'(len)) begin
        if (b < 8) ulow[8*b +: 8] = 8'h00;
        else uhigh[8*(b-8) +: 8] = 8'h00;
      end
    end
    if (rd.func == FuncStart) begin
      sh_mode = rd.reader_ok ? ModeCodeReady : ModeCodeError;
      v.outcome = rd.reader_ok ? OutStartOk : OutStartFail;
    end else if (sh_mode == ModeCodeIdle) begin
      v.outcome = OutNone;
    end else if (sh_mode == ModeCodeError) begin
      since = rd.now_ms - sh_retry_ms;
      if (since > win_retry) begin
        sh_retry_ms = rd.now_ms;
        if (rd.reader_ok) begin
          sh_mode = ModeCodeReady;
          v.outcome = OutRecovered;
        end else begin
          v.outcome = OutRetryFail;
        end
      end else begin
        v.outcome = OutErrorWait;
      end
    end else begin
      // The cooldown test is a plain compare, not a wrapping one.
      if (sh_mode == ModeCodeBusy && rd.now_ms >= sh_busy_end) begin
        sh_mode = ModeCodeReady;
        v.became_ready = 1'b1;
      end
      since = rd.now_ms - sh_seen_ms;
      if (!rd.tag_present) begin
        v.outcome = OutNone;
      end else if (len == sh_uid_len && ulow == sh_uid_low && uhigh == sh_uid_high &&
                   since < win_dup) begin
        sh_seen_ms = rd.now_ms;
        v.outcome = OutDuplicate;
      end else if (sh_mode == ModeCodeBusy) begin
        v.outcome = OutBusyReject;
      end else begin
        v.outcome = OutTap;
        v.ev_low = ulow;
        v.ev_high = uhigh;
        v.ev_len = len;
        v.ev_time = rd.now_ms;
        v.ev_seq = sh_taps;
        sh_taps = sh_taps + 1'b1;
        sh_uid_low = ulow;
        sh_uid_high = uhigh;
        sh_uid_len = len;
        sh_seen_ms = rd.now_ms;
        sh_mode = ModeCodeBusy;
        sh_busy_end = rd.now_ms + win_cool;
      end
    end
    v.mode = sh_mode;
    return v;
  endfunction

  // Builds a mostly well-formed random read: a known tag with fresh garbage past its
  // length, and a time that often lands right on one of the window edges.
  function automatic item_t make_random_read();
    item_t it;
    logic [UidLowW-1:0]  src_low;
    logic [UidHighW-1:0] src_high;
    int pick;
    int k;
    int b;
    it.func = ($urandom_range(0, 99) < 4) ? FuncStart : FuncPoll;
    if (it.func == FuncStart) it.reader_ok = ($urandom_range(0, 3) != 0);
    else it.reader_ok = 1'($urandom_range(0, 1));
    it.tag_present = ($urandom_range(0, 99) < 85);
    it.uid_low = {$urandom(), $urandom()};
    it.uid_high = 16'($urandom());
    src_low = it.uid_low;
    src_high = it.uid_high;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      src_low = sh_uid_low;
      src_high = sh_uid_high;
      it.uid_len = sh_uid_len;
      if (sh_uid_len == MaxUidBytes && $urandom_range(0, 1) == 1)
        it.uid_len = 4'($urandom_range(10, 15));
    end else if (pick < 8) begin
      k = $urandom_range(0, 3);
      src_low = pool_low[k];
      src_high = pool_high[k];
      it.uid_len = pool_len[k];
    end else begin
      it.uid_len = 4'($urandom_range(0, 15));
    end
    for (b = 0; b < int'(MaxUidBytes); b++) begin
      if (b < int'(it.uid_len)) begin
        if (b < 8) it.uid_low[8*b +: 8] = src_low[8*b +: 8];
        else it.uid_high[8*(b-8) +: 8] = src_high[8*(b-8) +: 8];
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ms_clock = ms_clock + 32'($urandom_range(0, 60));
    end else if (pick < 70) begin
      ms_clock = ms_clock + 32'($urandom_range(0, 4000));
    end else if (pick < 85) begin
      case ($urandom_range(0, 5))
        0:       ms_clock = sh_seen_ms + win_dup - 1'b1;
        1:       ms_clock = sh_seen_ms + win_dup;
        2:       ms_clock = sh_busy_end - 1'b1;
        3:       ms_clock = sh_busy_end;
        4:       ms_clock = sh_retry_ms + win_retry;
        default: ms_clock = sh_retry_ms + win_retry + 1'b1;
      endcase
    end else if (pick < 90) begin
      ms_clock = $urandom();
    end
    it.now_ms = ms_clock;
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compares the result on the ports with the oldest prediction.
  task automatic match_verdict();
    tap_result_t want;
    if (predicted_verdicts.size() == 0) begin
      $error("result transfer with no read waiting for it (outcome %0d)", outcome_o);
      mismatches++;
    end else begin
      want = predicted_verdicts.pop_front();
      verdicts_seen++;
      outcome_tally[int'(want.outcome)]++;
      check_field("outcome", 64'(want.outcome), 64'(outcome_o));
      check_field("became_ready", 64'(want.became_ready), 64'(became_ready_o));
      check_field("mode_out", 64'(want.mode), 64'(mode_out_o));
      check_field("event_uid_low", want.ev_low, event_uid_low_o);
      check_field("event_uid_high", 64'(want.ev_high), 64'(event_uid_high_o));
      check_field("event_uid_len", 64'(want.ev_len), 64'(event_uid_len_o));
      check_field("event_time_ms", 64'(want.ev_time), 64'(event_time_ms_o));
      check_field("event_seq", 64'(want.ev_seq), 64'(event_seq_o));
    end
  endtask

  // Offers one read, after an occasional idle burst, and holds it until the block takes
  // it. The prediction is made at the transfer, so it sees every earlier read.
  task automatic present_read(input item_t rd, input logic typed, input outcome_e t_outcome,
                              input logic [1:0] t_mode);
    tap_result_t want;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    func_i <= rd.func;
    reader_ok_i <= rd.reader_ok;
    tag_present_i <= rd.tag_present;
    uid_low_i <= rd.uid_low;
    uid_high_i <= rd.uid_high;
    uid_len_i <= rd.uid_len;
    now_ms_i <= rd.now_ms;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    want = qualify_read(rd);
    if (typed) begin
      want.outcome = t_outcome;
      want.mode = t_mode;
    end
    predicted_verdicts.push_back(want);
    reads_sent++;
  endtask

  // Stops offering and waits until every predicted result has come out. Since every read
  // gives exactly one result, the block is idle afterwards.
  task automatic drain();
    push <= 1'b0;
    while (predicted_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it in the shadow settings; index 3 is ignored.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgDupWindow:  win_dup = value;
      CfgBusyCool:   win_cool = value;
      CfgRetryIntvl: win_retry = value;
      default: ;
    endcase
  endtask

  // Result side: pops with random stall bursts, and once holds off long enough for the
  // block to fill up and push back on the sender.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    wait (rst_ni == 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) match_verdict();
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        hold_left = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side means the block is stuck.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed script, then random phases under different windows.
  initial begin
    int ph;
    int k;
    rst_ni = 1'b0;
    push = 1'b0;
    func_i = FuncStart;
    reader_ok_i = 1'b0;
    tag_present_i = 1'b0;
    uid_low_i = '0;
    uid_high_i = '0;
    uid_len_i = '0;
    now_ms_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgDupWindow;
    cfg_data_i = '0;
    ms_clock = 32'h0000_1000;
    hold_request = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    reads_sent = 0;
    verdicts_seen = 0;
    settings_used = 1;
    quiet_cycles = 0;
    foreach (outcome_tally[k]) outcome_tally[k] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (read_script[k])
      present_read(read_script[k].rd, read_script[k].typed, read_script[k].outcome,
                   read_script[k].mode);
    drain();

    for (ph = 0; ph < PhaseCount; ph++) begin
      // Phases: moderate random windows, all zero, all ones, mixed extremes, and a last
      // moderate one with no idling on either side.
      case (ph)
        1: begin
          write_reg(CfgDupWindow, 32'd0);
          write_reg(CfgBusyCool, 32'd0);
          write_reg(CfgRetryIntvl, 32'd0);
        end
        2: begin
          write_reg(CfgDupWindow, 32'hFFFF_FFFF);
          write_reg(CfgBusyCool, 32'hFFFF_FFFF);
          write_reg(CfgRetryIntvl, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CfgDupWindow, 32'hFFFF_FFFF);
          write_reg(CfgBusyCool, 32'd1);
          write_reg(CfgRetryIntvl, 32'd0);
        end
        default: begin
          write_reg(CfgDupWindow, 32'($urandom_range(300, 3000)));
          write_reg(CfgBusyCool, 32'($urandom_range(100, 2500)));
          write_reg(CfgRetryIntvl, 32'($urandom_range(200, 4000)));
        end
      endcase
      write_reg(CfgUnused, $urandom());
      cfg_we_i <= 1'b0;
      settings_used++;
      if (ph == 1) hold_request = 1'b1;
      if (ph == PhaseCount - 1) calm = 1'b1;
      for (k = 0; k < 4; k++) begin
        pool_low[k] = {$urandom(), $urandom()};
        pool_high[k] = 16'($urandom());
        case ($urandom_range(0, 5))
          0:       pool_len[k] = 4'd4;
          1:       pool_len[k] = 4'd7;
          2:       pool_len[k] = MaxUidBytes;
          3:       pool_len[k] = 4'($urandom_range(11, 15));
          default: pool_len[k] = 4'($urandom_range(0, 10));
        endcase
      end
      for (k = 0; k < ReadsPerPhase; k++) begin
        // Once, the sender waits in mid-phase until the block has delivered everything.
        if (ph == 0 && k == ReadsPerPhase / 2) drain();
        present_read(make_random_read(), 1'b0, OutNone, ModeCodeIdle);
      end
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Run: %0d reads, %0d results checked, %0d window settings.",
             reads_sent, verdicts_seen, settings_used);
    $display("Taps %0d, duplicates %0d, busy rejects %0d, retries %0d failed %0d recovered.",
             outcome_tally[OutTap], outcome_tally[OutDuplicate], outcome_tally[OutBusyReject],
             outcome_tally[OutRetryFail], outcome_tally[OutRecovered]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ttq_pkg.sv
hdl/ttq_front.sv
hdl/ttq_fifo.sv
hdl/ttq_core.sv
hdl/tag_tap_qualifier.sv
bench/tb_tag_tap_qualifier.sv
